// ===== src/subset_sum_enumerator_macros.svh =====
// assertion macros used by sse_back
`ifndef SUBSET_SUM_ENUMERATOR_MACROS_SVH
`define SUBSET_SUM_ENUMERATOR_MACROS_SVH

`ifndef NO_ASSERTIONS
`define SSE_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define SSE_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define SSE_ASSERT_IMPLIES(label, clk, rst, ante, cons)
`define SSE_ASSERT_NEXT(label, clk, rst, ante, cons)
`endif

`endif

// ===== src/sse_pkg.sv =====
`timescale 1ns / 1ps

package sse_pkg;

  localparam int DATA_W = 32;

  localparam logic [1:0] OP_CLEAR = 2'd0;
  localparam logic [1:0] OP_LOAD  = 2'd1;
  localparam logic [1:0] OP_STEP  = 2'd2;

  typedef enum logic [1:0] {
    CMD_CLEAR,
    CMD_LOAD,
    CMD_STEP
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t          kind;
    logic [DATA_W-1:0]  value;
  } cmd_t;

  typedef enum logic [2:0] {
    BK_IDLE,
    BK_SUM,
    BK_CMP,
    BK_EMIT_SCAN,
    BK_EMIT_WR,
    BK_EMPTY,
    BK_EXH
  } back_state_t;

endpackage

// ===== src/sse_ram.sv =====
`timescale 1ns / 1ps

module sse_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                                      clk,
  input  logic                                      we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                          wdata,
  input  logic                                      re,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                          rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ===== src/sse_front.sv =====
`timescale 1ns / 1ps

module sse_front (
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic [1:0]                  op,
  input  logic [sse_pkg::DATA_W-1:0]  value,
  input  logic                        q_ready,
  output logic                        q_push,
  output sse_pkg::cmd_t               q_cmd
);

  logic known;

  // unused op code is taken and dropped
  always_comb begin
    known       = 1'b1;
    q_cmd.value = value;
    q_cmd.kind  = sse_pkg::CMD_STEP;
    unique case (op)
      sse_pkg::OP_CLEAR: q_cmd.kind = sse_pkg::CMD_CLEAR;
      sse_pkg::OP_LOAD:  q_cmd.kind = sse_pkg::CMD_LOAD;
      sse_pkg::OP_STEP:  q_cmd.kind = sse_pkg::CMD_STEP;
      default:           known      = 1'b0;
    endcase
  end

  assign item_ready = q_ready;
  assign q_push     = item_valid && q_ready && known;

endmodule

// ===== src/sse_queue.sv =====
`timescale 1ns / 1ps

module sse_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  sse_pkg::cmd_t  push_cmd,
  output logic           push_ready,
  output logic           pop_valid,
  output sse_pkg::cmd_t  pop_cmd,
  input  logic           pop
);

  sse_pkg::cmd_t entries [2];
  logic          wr_ptr;
  logic          rd_ptr;
  logic [1:0]    fill;

  assign push_ready = (fill != 2'd2);
  assign pop_valid  = (fill != 2'd0);
  assign pop_cmd    = entries[rd_ptr];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      fill   <= 2'd0;
    end else begin
      if (push) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && pop_valid) begin
        rd_ptr <= ~rd_ptr;
      end
      fill <= fill + 2'(push) - 2'(pop && pop_valid);
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      entries[wr_ptr] <= push_cmd;
    end
  end

endmodule

// ===== src/sse_back.sv =====
`timescale 1ns / 1ps
`include "subset_sum_enumerator_macros.svh"

module sse_back #(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        q_valid,
  input  sse_pkg::cmd_t               q_cmd,
  output logic                        q_ready,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sse_pkg::DATA_W-1:0]  cfg_data,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [sse_pkg::DATA_W-1:0]  element,
  output logic                        last_of_subset,
  output logic                        empty_subset,
  output logic                        exhausted
);

  localparam int IW = (MAX_ELEMENTS > 1) ? $clog2(MAX_ELEMENTS) : 1;
  localparam int NW = $clog2(MAX_ELEMENTS + 1);
  localparam int CW = MAX_ELEMENTS + 1;
  localparam int SW = sse_pkg::DATA_W + $clog2(MAX_ELEMENTS);

  sse_pkg::back_state_t state, state_next;

  logic [NW-1:0]               count, count_next;
  logic [CW-1:0]               counter, counter_next;
  logic [NW-1:0]               idx, idx_next;
  logic [NW-1:0]               didx, didx_next;
  logic                        dvalid, dvalid_next;
  logic signed [SW-1:0]        sum, sum_next;
  logic [sse_pkg::DATA_W-1:0]  target;
  logic                        result_valid_next;
  logic [sse_pkg::DATA_W-1:0]  element_next;
  logic                        last_next, empty_next, exhausted_next;

  logic                        ram_we, ram_re;
  logic [sse_pkg::DATA_W-1:0]  ram_rdata;

  logic [NW-1:0]               sh, sh_d;
  logic                        sel, sel_d, more, at_end, slot_free;
  logic [CW-1:0]               mask_lo;

  sse_ram #(
    .WIDTH (sse_pkg::DATA_W),
    .DEPTH (MAX_ELEMENTS)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (count[IW-1:0]),
    .wdata (q_cmd.value),
    .re    (ram_re),
    .raddr (idx[IW-1:0]),
    .rdata (ram_rdata)
  );

  // element i maps to counter bit count-1-i
  assign sh        = count - NW'(1) - idx;
  assign sh_d      = count - NW'(1) - didx;
  assign sel       = counter[sh];
  assign sel_d     = counter[sh_d];
  assign mask_lo   = ~({CW{1'b1}} << sh);
  assign more      = |(counter & mask_lo);
  assign at_end    = |(counter >> count);
  assign slot_free = !result_valid || result_ready;
  assign cfg_ready = 1'b1;

  always_comb begin
    state_next        = state;
    count_next        = count;
    counter_next      = counter;
    idx_next          = idx;
    didx_next         = didx;
    dvalid_next       = 1'b0;
    sum_next          = sum;
    result_valid_next = result_valid && !result_ready;
    element_next      = element;
    last_next         = last_of_subset;
    empty_next        = empty_subset;
    exhausted_next    = exhausted;
    q_ready           = 1'b0;
    ram_we            = 1'b0;
    ram_re            = 1'b0;
    unique case (state)
      sse_pkg::BK_IDLE: begin
        q_ready = 1'b1;
        if (q_valid) begin
          case (q_cmd.kind)
            sse_pkg::CMD_CLEAR: begin
              count_next   = '0;
              counter_next = '0;
            end
            sse_pkg::CMD_LOAD: begin
              if (count < NW'(MAX_ELEMENTS)) begin
                ram_we     = 1'b1;
                count_next = count + NW'(1);
              end
              counter_next = '0;
            end
            default: begin
              idx_next = '0;
              sum_next = '0;
              if (count == '0 || at_end) begin
                state_next = sse_pkg::BK_EXH;
              end else begin
                state_next = sse_pkg::BK_SUM;
              end
            end
          endcase
        end
      end
      sse_pkg::BK_SUM: begin
        // reads issue back to back, data lands in the cycle after the read
        if (idx != count) begin
          ram_re      = 1'b1;
          idx_next    = idx + NW'(1);
          didx_next   = idx;
          dvalid_next = 1'b1;
        end
        if (dvalid && sel_d) begin
          sum_next = sum + SW'(signed'(ram_rdata));
        end
        if (idx == count && !dvalid) begin
          state_next = sse_pkg::BK_CMP;
        end
      end
      sse_pkg::BK_CMP: begin
        idx_next = '0;
        if (sum == SW'(signed'(target))) begin
          if (counter == '0) begin
            state_next = sse_pkg::BK_EMPTY;
          end else begin
            state_next = sse_pkg::BK_EMIT_SCAN;
          end
        end else begin
          counter_next = counter + CW'(1);
          state_next   = sse_pkg::BK_IDLE;
        end
      end
      sse_pkg::BK_EMIT_SCAN: begin
        if (sel) begin
          ram_re     = 1'b1;
          state_next = sse_pkg::BK_EMIT_WR;
        end else begin
          idx_next = idx + NW'(1);
        end
      end
      sse_pkg::BK_EMIT_WR: begin
        if (slot_free) begin
          result_valid_next = 1'b1;
          element_next      = ram_rdata;
          last_next         = !more;
          empty_next        = 1'b0;
          exhausted_next    = 1'b0;
          if (more) begin
            idx_next   = idx + NW'(1);
            state_next = sse_pkg::BK_EMIT_SCAN;
          end else begin
            counter_next = counter + CW'(1);
            state_next   = sse_pkg::BK_IDLE;
          end
        end
      end
      sse_pkg::BK_EMPTY: begin
        if (slot_free) begin
          result_valid_next = 1'b1;
          element_next      = '0;
          last_next         = 1'b1;
          empty_next        = 1'b1;
          exhausted_next    = 1'b0;
          counter_next      = counter + CW'(1);
          state_next        = sse_pkg::BK_IDLE;
        end
      end
      sse_pkg::BK_EXH: begin
        if (slot_free) begin
          result_valid_next = 1'b1;
          element_next      = '0;
          last_next         = 1'b0;
          empty_next        = 1'b0;
          exhausted_next    = 1'b1;
          state_next        = sse_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = sse_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= sse_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count        <= '0;
      counter      <= '0;
      dvalid       <= 1'b0;
      result_valid <= 1'b0;
      target       <= '0;
    end else begin
      count        <= count_next;
      counter      <= counter_next;
      dvalid       <= dvalid_next;
      result_valid <= result_valid_next;
      if (cfg_valid) begin
        target <= cfg_data;
      end
    end
  end

  always_ff @(posedge clk) begin
    idx            <= idx_next;
    didx           <= didx_next;
    sum            <= sum_next;
    element        <= element_next;
    last_of_subset <= last_next;
    empty_subset   <= empty_next;
    exhausted      <= exhausted_next;
  end

  `SSE_ASSERT_IMPLIES(a_count_range, clk, rst, 1'b1, count <= NW'(MAX_ELEMENTS))
  `SSE_ASSERT_IMPLIES(a_empty_is_last, clk, rst, result_valid && empty_subset, last_of_subset && element == '0)
  `SSE_ASSERT_IMPLIES(a_exh_clean, clk, rst, result_valid && exhausted, !last_of_subset && !empty_subset)
  `SSE_ASSERT_NEXT(a_sum_exit, clk, rst, state == sse_pkg::BK_SUM, state == sse_pkg::BK_SUM || state == sse_pkg::BK_CMP)

endmodule

// ===== src/subset_sum_enumerator.sv =====
`timescale 1ns / 1ps
// channel  dir  handshake                    payload
// item     in   item_valid / item_ready      op, value
// result   out  result_valid / result_ready  element, last_of_subset, empty_subset, exhausted
// config   in   cfg_valid / cfg_ready        target_sum
//
// clear and load are taken from the idle state; op code 3 is dropped at the front
// a step over n elements reads them in turn, bound by the one read port, then compares the sum;
// a match then scans the elements up to its last one and reports each element in it,
// or reports the empty subset
// reset empties the list and the subset counter and sets the target to 0, not the store
// a held result stalls the back end; the two-item queue then fills and item_ready drops

module subset_sum_enumerator #(
  parameter int MAX_ELEMENTS = 16
) (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        item_valid,
  output logic                        item_ready,
  input  logic [1:0]                  op,
  input  logic [sse_pkg::DATA_W-1:0]  value,
  input  logic                        cfg_valid,
  output logic                        cfg_ready,
  input  logic [sse_pkg::DATA_W-1:0]  target_sum,
  output logic                        result_valid,
  input  logic                        result_ready,
  output logic [sse_pkg::DATA_W-1:0]  element,
  output logic                        last_of_subset,
  output logic                        empty_subset,
  output logic                        exhausted
);

  logic          push, push_ready, pop_valid, pop;
  sse_pkg::cmd_t push_cmd, pop_cmd;

  sse_front u_front (
    .item_valid (item_valid),
    .item_ready (item_ready),
    .op         (op),
    .value      (value),
    .q_ready    (push_ready),
    .q_push     (push),
    .q_cmd      (push_cmd)
  );

  sse_queue u_queue (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .push_cmd   (push_cmd),
    .push_ready (push_ready),
    .pop_valid  (pop_valid),
    .pop_cmd    (pop_cmd),
    .pop        (pop)
  );

  sse_back #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_back (
    .clk            (clk),
    .rst            (rst),
    .q_valid        (pop_valid),
    .q_cmd          (pop_cmd),
    .q_ready        (pop),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (target_sum),
    .result_valid   (result_valid),
    .result_ready   (result_ready),
    .element        (element),
    .last_of_subset (last_of_subset),
    .empty_subset   (empty_subset),
    .exhausted      (exhausted)
  );

endmodule

// ===== verif/testbench.sv =====
`timescale 1ns / 1ps

module testbench;

  localparam int MAX_ELEMENTS = 16;
  localparam int RANDOM_ITEMS = 330;
  localparam int SETTLE_CYCLES = 100;
  localparam int HOLD_CYCLES = 300;
  localparam int WATCHDOG_LIMIT = 3000;
  localparam logic [1:0] OP_CLEAR = sse_pkg::OP_CLEAR;
  localparam logic [1:0] OP_LOAD = sse_pkg::OP_LOAD;
  localparam logic [1:0] OP_STEP = sse_pkg::OP_STEP;
  localparam logic [1:0] OP_UNUSED = 2'd3;
  localparam logic [31:0] VALUE_MAX = 32'h7FFF_FFFF;
  localparam logic [31:0] VALUE_MIN = 32'h8000_0000;

  typedef struct packed {
    logic [31:0] element;
    logic        last_of_subset;
    logic        empty_subset;
    logic        exhausted;
  } result_t;

  localparam result_t EXHAUSTED_RES = '{32'd0, 1'b0, 1'b0, 1'b1};
  localparam result_t EMPTY_SET_RES = '{32'd0, 1'b1, 1'b1, 1'b0};

  typedef enum logic {
    ROW_ITEM,
    ROW_CFG
  } row_kind_t;

  typedef struct {
    row_kind_t   kind;
    logic [1:0]  cmd;
    logic [31:0] data;
    bit          typed;
    result_t     typed_res;
  } dir_row_t;

  logic        clk;
  logic        rst = 1'b1;
  logic        item_valid = 1'b0;
  logic        item_ready;
  logic [1:0]  op = OP_CLEAR;
  logic [31:0] value = '0;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [31:0] target_sum = '0;
  logic        result_valid;
  logic        result_ready = 1'b0;
  logic [31:0] element;
  logic        last_of_subset;
  logic        empty_subset;
  logic        exhausted;

  // local copy of the block state
  logic signed [31:0] elem_list [MAX_ELEMENTS];
  int                 list_len = 0;
  int                 subset_idx = 0;
  logic signed [31:0] target_reg = '0;

  result_t  expected_results[$];
  dir_row_t directed_rows[$];
  int       failures = 0;
  int       items_accepted = 0;
  int       stalled_cycles = 0;
  bit       send_burst = 1'b0;
  bit       recv_burst = 1'b0;
  bit       backpressure_request = 1'b0;

  subset_sum_enumerator #(
    .MAX_ELEMENTS(MAX_ELEMENTS)
  ) i_dut (
    .clk(clk),
    .rst(rst),
    .item_valid(item_valid),
    .item_ready(item_ready),
    .op(op),
    .value(value),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .target_sum(target_sum),
    .result_valid(result_valid),
    .result_ready(result_ready),
    .element(element),
    .last_of_subset(last_of_subset),
    .empty_subset(empty_subset),
    .exhausted(exhausted)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic void advance_enumeration(input logic [1:0] cmd, input logic [31:0] data,
                                              ref result_t outq[$]);
    longint  acc;
    int      n;
    result_t r;
    outq.delete();
    case (cmd)
      OP_CLEAR: begin
        list_len = 0;
        subset_idx = 0;
      end
      OP_LOAD: begin
        if (list_len < MAX_ELEMENTS) begin
          elem_list[list_len] = data;
          list_len++;
        end
        subset_idx = 0;
      end
      OP_STEP: begin
        n = list_len;
        if (n == 0 || subset_idx >= (1 << n)) begin
          outq.push_back(EXHAUSTED_RES);
        end else begin
          acc = 0;
          for (int i = 0; i < n; i++) begin
            if (subset_idx[n-1-i]) acc += longint'(elem_list[i]);
          end
          if (acc == longint'(target_reg)) begin
            for (int i = 0; i < n; i++) begin
              if (subset_idx[n-1-i]) begin
                r = '{elem_list[i], 1'b0, 1'b0, 1'b0};
                outq.push_back(r);
              end
            end
            if (outq.size() == 0) outq.push_back(EMPTY_SET_RES);
            else outq[outq.size()-1].last_of_subset = 1'b1;
          end
          subset_idx++;
        end
      end
      default: ;
    endcase
  endfunction

  function automatic dir_row_t mk_row(input row_kind_t kind, input logic [1:0] cmd,
                                      input logic [31:0] data, input bit typed,
                                      input result_t res);
    dir_row_t row;
    row.kind = kind;
    row.cmd = cmd;
    row.data = data;
    row.typed = typed;
    row.typed_res = res;
    return row;
  endfunction

  function automatic void check_field(input string name, input logic [31:0] exp_val,
                                      input logic [31:0] act_val);
    if (act_val !== exp_val) begin
      $display("%0t: %s mismatch, expected %h, actual %h", $time, name, exp_val, act_val);
      failures++;
    end
  endfunction

  task automatic send_item(input logic [1:0] cmd, input logic [31:0] data, input bit typed,
                           input result_t typed_res);
    int      gap;
    bit      took;
    result_t fresh[$];
    gap = send_burst ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      item_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    item_valid <= 1'b1;
    op <= cmd;
    value <= data;
    do begin
      @(negedge clk);
      took = item_ready;
      @(posedge clk);
    end while (!took);
    advance_enumeration(cmd, data, fresh);
    if (typed) expected_results.push_back(typed_res);
    else foreach (fresh[j]) expected_results.push_back(fresh[j]);
    if (cmd != OP_UNUSED) items_accepted++;
  endtask

  task automatic wait_idle();
    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_target(input logic [31:0] data);
    bit took;
    cfg_valid <= 1'b1;
    target_sum <= data;
    do begin
      @(negedge clk);
      took = cfg_ready;
      @(posedge clk);
    end while (!took);
    cfg_valid <= 1'b0;
    target_reg = data;
  endtask

  // result side ready pattern
  initial begin : result_sink
    int gap;
    bit took;
    wait (!rst);
    @(posedge clk);
    forever begin
      if (backpressure_request) begin
        backpressure_request = 1'b0;
        result_ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      gap = recv_burst ? 0 : $urandom_range(0, 11);
      if (gap > 0) begin
        result_ready <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      result_ready <= 1'b1;
      do begin
        @(negedge clk);
        took = result_valid || backpressure_request;
        @(posedge clk);
      end while (!took);
    end
  end

  always @(negedge clk) begin
    result_t exp_res;
    if (!rst) begin
      if (result_valid && result_ready) begin
        if (expected_results.size() == 0) begin
          $display("%0t: unexpected item, expected none, actual %h %b %b %b", $time,
                   element, last_of_subset, empty_subset, exhausted);
          failures++;
        end else begin
          exp_res = expected_results.pop_front();
          check_field("element", exp_res.element, element);
          check_field("last_of_subset", 32'(exp_res.last_of_subset), 32'(last_of_subset));
          check_field("empty_subset", 32'(exp_res.empty_subset), 32'(empty_subset));
          check_field("exhausted", 32'(exp_res.exhausted), 32'(exhausted));
        end
      end
      if ((item_valid && item_ready) || (result_valid && result_ready) ||
          (cfg_valid && cfg_ready)) begin
        stalled_cycles = 0;
      end else begin
        stalled_cycles++;
      end
      if (stalled_cycles >= WATCHDOG_LIMIT) begin
        $display("%0t: watchdog, no handshake for %0d cycles", $time, stalled_cycles);
        $display("Test completed with failures");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int          phase_idx;
    int          kind;
    int          n;
    int          steps;
    int          k;
    int          item_goal;
    int unsigned mask;
    bit          full_rand;
    longint      acc;
    logic [31:0] tgt;
    logic [31:0] vals[$];

    // after reset, extremes, exact sums
    directed_rows.push_back(mk_row(ROW_ITEM, OP_STEP, 32'd0, 1'b1, EXHAUSTED_RES));
    directed_rows.push_back(mk_row(ROW_ITEM, OP_UNUSED, 32'hFFFF_FFFF, 1'b0, '0));
    directed_rows.push_back(mk_row(ROW_ITEM, OP_LOAD, VALUE_MIN, 1'b0, '0));
    directed_rows.push_back(mk_row(ROW_ITEM, OP_LOAD, VALUE_MAX, 1'b0, '0));
    directed_rows.push_back(mk_row(ROW_ITEM, OP_STEP, 32'd0, 1'b1, EMPTY_SET_RES));
    repeat (3) directed_rows.push_back(mk_row(ROW_ITEM, OP_STEP, 32'd0, 1'b0, '0));
    directed_rows.push_back(mk_row(ROW_ITEM, OP_STEP, 32'd0, 1'b1, EXHAUSTED_RES));
    directed_rows.push_back(mk_row(ROW_ITEM, OP_CLEAR, 32'd0, 1'b0, '0));
    directed_rows.push_back(mk_row(ROW_ITEM, OP_STEP, 32'd0, 1'b1, EXHAUSTED_RES));
    directed_rows.push_back(mk_row(ROW_CFG, OP_CLEAR, 32'hFFFF_FFFF, 1'b0, '0));
    directed_rows.push_back(mk_row(ROW_ITEM, OP_LOAD, VALUE_MIN, 1'b0, '0));
    directed_rows.push_back(mk_row(ROW_ITEM, OP_LOAD, VALUE_MAX, 1'b0, '0));
    repeat (4) directed_rows.push_back(mk_row(ROW_ITEM, OP_STEP, 32'd0, 1'b0, '0));
    directed_rows.push_back(mk_row(ROW_CFG, OP_CLEAR, 32'd0, 1'b0, '0));
    directed_rows.push_back(mk_row(ROW_ITEM, OP_CLEAR, 32'd0, 1'b0, '0));
    directed_rows.push_back(mk_row(ROW_ITEM, OP_LOAD, VALUE_MIN, 1'b0, '0));
    directed_rows.push_back(mk_row(ROW_ITEM, OP_LOAD, VALUE_MIN, 1'b0, '0));
    directed_rows.push_back(mk_row(ROW_ITEM, OP_STEP, 32'd0, 1'b1, EMPTY_SET_RES));
    repeat (3) directed_rows.push_back(mk_row(ROW_ITEM, OP_STEP, 32'd0, 1'b0, '0));
    directed_rows.push_back(mk_row(ROW_ITEM, OP_STEP, 32'd0, 1'b1, EXHAUSTED_RES));

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    foreach (directed_rows[r]) begin
      if (directed_rows[r].kind == ROW_CFG) begin
        wait_idle();
        write_target(directed_rows[r].data);
      end else begin
        send_item(directed_rows[r].cmd, directed_rows[r].data, directed_rows[r].typed,
                  directed_rows[r].typed_res);
      end
    end

    item_goal = items_accepted + RANDOM_ITEMS;
    phase_idx = 0;
    while (items_accepted < item_goal) begin
      kind = (phase_idx < 4) ? 0 : $urandom_range(0, 9);
      send_burst = ($urandom_range(0, 3) == 0);
      recv_burst = ($urandom_range(0, 3) == 0);
      vals.delete();
      if (kind <= 6) begin
        // clear, load a short list, walk every subset and sometimes past the end
        n = (phase_idx == 3) ? 5 : $urandom_range((phase_idx < 2) ? 1 : 0, 5);
        full_rand = (phase_idx < 2) || ($urandom_range(0, 1) == 1);
        for (int i = 0; i < n; i++) begin
          // all zero values make every subset match and keep the result side busy
          vals.push_back((phase_idx == 3) ? 32'd0 :
                         (full_rand ? $urandom : 32'(int'($urandom_range(0, 16)) - 8)));
        end
        if (phase_idx < 2) begin
          tgt = (phase_idx == 0) ? VALUE_MAX : VALUE_MIN;
          vals[$urandom_range(0, n - 1)] = tgt;
        end else if (phase_idx == 3) begin
          tgt = '0;
        end else begin
          mask = $urandom_range(0, (1 << n) - 1);
          acc = 0;
          for (int i = 0; i < n; i++) begin
            if (mask[n-1-i]) acc += longint'($signed(vals[i]));
          end
          tgt = (acc == longint'($signed(32'(acc)))) ? 32'(acc) : $urandom;
        end
        steps = (1 << n) + $urandom_range(0, 2);
      end else if (kind == 7) begin
        // full list, sometimes with loads past capacity, match among the first subsets
        n = MAX_ELEMENTS + $urandom_range(0, 3);
        for (int i = 0; i < n; i++) vals.push_back(32'(int'($urandom_range(0, 8)) - 4));
        k = $urandom_range(0, 3);
        acc = 0;
        for (int i = MAX_ELEMENTS - k; i < MAX_ELEMENTS; i++) acc += longint'($signed(vals[i]));
        tgt = 32'(acc);
        steps = $urandom_range(8, 20);
      end else begin
        n = $urandom_range(6, 14);
        tgt = $urandom;
        steps = 0;
      end

      wait_idle();
      write_target(tgt);
      if (phase_idx == 3) begin
        recv_burst = 1'b0;
        backpressure_request = 1'b1;
      end

      if (kind <= 7) begin
        send_item(OP_CLEAR, $urandom, 1'b0, '0);
        foreach (vals[j]) send_item(OP_LOAD, vals[j], 1'b0, '0);
        repeat (steps) send_item(OP_STEP, $urandom, 1'b0, '0);
      end else begin
        repeat (n) send_item(2'($urandom_range(0, 3)), $urandom, 1'b0, '0);
      end
      phase_idx++;
    end

    item_valid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (failures == 0) begin
      $display("Test completed successfully");
    end else begin
      $display("Test completed with failures");
    end
    $finish;
  end

endmodule
